@@ hdl/hsc_pkg.sv @@
// Shared types, constants and helpers for the relief-shaded height colorizer.
// No dependencies; every other file depends on this package.
`default_nettype none
package hsc_pkg;

   localparam int HEIGHT_BITS = 16;
   localparam int UP_SHIFT    = (HEIGHT_BITS < 16) ? 16 - HEIGHT_BITS : 0;
   localparam int DN_SHIFT    = (HEIGHT_BITS > 16) ? HEIGHT_BITS - 16 : 0;

   // Square-root pipeline: one result bit per stage over a 64-bit radicand
   localparam int SQRT_STAGES = 32;
   // Divider pipeline: one quotient bit per stage; larger quotients saturate
   localparam int DIV_STAGES  = 16;

   localparam logic [15:0] LIGHT_MIN = 16'd13107;
   localparam logic [15:0] LIGHT_MAX = 16'd36044;
   localparam logic [15:0] LIGHT_ONE = 16'd32768;

   // Register indexes on the configuration port
   typedef enum logic [1:0] {
      REG_SEA_LEVEL   = 2'd0,
      REG_GRASS_TOP   = 2'd1,
      REG_ROCK_TOP    = 2'd2,
      REG_RELIEF_GAIN = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [15:0] sea_level;
      logic [15:0] grass_top;
      logic [15:0] rock_top;
      logic [7:0]  relief_gain;
   } cfg_type;

   // Data that rides alongside the light computation
   typedef struct packed {
      logic        num_pos;
      logic [27:0] num;
      logic        water;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } side_type;

   // Bring a height to Q0.16
   function automatic logic [15:0] to_q16(input logic [HEIGHT_BITS-1:0] h);
      logic [HEIGHT_BITS+15:0] t;
      t = ({16'b0, h} << UP_SHIFT) >> DN_SHIFT;
      return t[15:0];
   endfunction

endpackage
`default_nettype wire

@@ hdl/hsc_if.sv @@
// Valid/ready channel interfaces for pixel requests and shaded responses.
// Depends on hsc_pkg for the height width.
`default_nettype none
interface hsc_req_if;
   logic                            valid;
   logic                            ready;
   logic [hsc_pkg::HEIGHT_BITS-1:0] center_height;
   logic [hsc_pkg::HEIGHT_BITS-1:0] left_height;
   logic [hsc_pkg::HEIGHT_BITS-1:0] right_height;
   logic [hsc_pkg::HEIGHT_BITS-1:0] up_height;
   logic [hsc_pkg::HEIGHT_BITS-1:0] down_height;
   logic                            overlay_valid;
   logic [7:0]                      overlay_red;
   logic [7:0]                      overlay_green;
   logic [7:0]                      overlay_blue;

   modport source (output valid, center_height, left_height, right_height, up_height,
                   down_height, overlay_valid, overlay_red, overlay_green, overlay_blue,
                   input ready);
   modport sink   (input valid, center_height, left_height, right_height, up_height,
                   down_height, overlay_valid, overlay_red, overlay_green, overlay_blue,
                   output ready);
endinterface

interface hsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_red;
   logic [7:0] pixel_green;
   logic [7:0] pixel_blue;

   modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
   modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface
`default_nettype wire

@@ hdl/hsc_front.sv @@
// Front end: slopes, squared normal length, light numerator and band colour.
// Depends on hsc_pkg; three register stages, all advancing on en.
`default_nettype none
module hsc_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            en,
   input  wire logic                            in_vld,
   input  wire logic [hsc_pkg::HEIGHT_BITS-1:0] center_height,
   input  wire logic [hsc_pkg::HEIGHT_BITS-1:0] left_height,
   input  wire logic [hsc_pkg::HEIGHT_BITS-1:0] right_height,
   input  wire logic [hsc_pkg::HEIGHT_BITS-1:0] up_height,
   input  wire logic [hsc_pkg::HEIGHT_BITS-1:0] down_height,
   input  wire logic                            overlay_valid,
   input  wire logic [7:0]                      overlay_red,
   input  wire logic [7:0]                      overlay_green,
   input  wire logic [7:0]                      overlay_blue,
   input  wire hsc_pkg::cfg_type                cfg,
   output logic                                 out_vld,
   output logic [63:0]                          out_rad,
   output hsc_pkg::side_type                    out_side
);
   import hsc_pkg::*;

   logic [15:0]        h, hl, hr, hu, hd, d, up_d;
   logic signed [16:0] dx, dy;
   logic signed [25:0] a_in, b_in;
   logic [22:0]        d100;
   logic [23:0]        tg_sum;
   logic [24:0]        tb_sum;
   logic [7:0]         tg;
   logic [8:0]         tb;
   logic [20:0]        beach_val;
   side_type           side1_in;
   side_type           side2_in;

   logic               vld1_ff, vld2_ff, vld3_ff;
   logic signed [25:0] a_ff, b_ff;
   side_type           side1_ff, side2_ff, side3_ff;
   logic [49:0]        aa_ff, bb_ff;
   logic signed [51:0] aa_full, bb_full;
   logic signed [29:0] num_in;
   logic [63:0]        rad_ff;
   logic [49:0]        q_sum;

   // Stage 1: gained differences and band colour
   always_comb begin
      h  = to_q16(center_height);
      hl = to_q16(left_height);
      hr = to_q16(right_height);
      hu = to_q16(up_height);
      hd = to_q16(down_height);
      dx = signed'({1'b0, hl}) - signed'({1'b0, hr});
      dy = signed'({1'b0, hu}) - signed'({1'b0, hd});
      a_in = 26'(dx) * signed'(26'({1'b0, cfg.relief_gain}));
      b_in = 26'(dy) * signed'(26'({1'b0, cfg.relief_gain}));

      d         = cfg.sea_level - h;
      up_d      = h - cfg.sea_level;
      d100      = 23'(d) * 23'd100;
      tg_sum    = 24'(d) * 24'd200 + 24'd65535;
      tb_sum    = 25'(d) * 25'd500 + 25'd65535;
      tg        = tg_sum[23:16];
      tb        = tb_sum[24:16];
      beach_val = 21'(up_d) * 21'd25;

      side1_in       = '0;
      side1_in.water = 1'b0;
      if (h < cfg.sea_level) begin
         side1_in.water = 1'b1;
         if (d100 < 23'd65536) begin
            side1_in.red = 8'd200; side1_in.green = 8'd220; side1_in.blue = 8'd255;
         end else begin
            side1_in.red   = 8'd10;
            side1_in.green = (tg >= 8'd80) ? 8'd0 : 8'd80 - tg;
            side1_in.blue  = (tb >= 9'd180) ? 8'd0 : 8'(9'd180 - tb);
         end
      end else if (beach_val < 21'd65536) begin
         side1_in.red = 8'd210; side1_in.green = 8'd200; side1_in.blue = 8'd130;
      end else if (h < cfg.grass_top) begin
         side1_in.red = 8'd60; side1_in.green = 8'd140; side1_in.blue = 8'd60;
      end else if (h < cfg.rock_top) begin
         side1_in.red = 8'd100; side1_in.green = 8'd90; side1_in.blue = 8'd80;
      end else begin
         side1_in.red = 8'd240; side1_in.green = 8'd240; side1_in.blue = 8'd255;
      end
      // Overlay replaces the band colour only
      if (overlay_valid) begin
         side1_in.red   = overlay_red;
         side1_in.green = overlay_green;
         side1_in.blue  = overlay_blue;
      end
   end

   // Stage 2: squares and light numerator
   always_comb begin
      aa_full = 52'(a_ff) * 52'(a_ff);
      bb_full = 52'(b_ff) * 52'(b_ff);
      num_in  = 30'(a_ff) * 30'sd5 + 30'(b_ff) * 30'sd5 + 30'sd458752;
      q_sum   = aa_ff + bb_ff + 50'h1_0000_0000;
      side2_in         = side1_ff;
      side2_in.num_pos = (num_in > 30'sd0);
      side2_in.num     = num_in[27:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         side1_ff <= side1_in;
         aa_ff    <= 50'(unsigned'(aa_full));
         bb_ff    <= 50'(unsigned'(bb_full));
         side2_ff <= side2_in;
         rad_ff   <= {q_sum, 14'b0};
         side3_ff <= side2_ff;
      end
   end

   assign out_vld  = vld3_ff;
   assign out_rad  = rad_ff;
   assign out_side = side3_ff;
endmodule
`default_nettype wire

@@ hdl/hsc_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on hsc_pkg for the stage count and the side payload type.
`default_nettype none
module hsc_isqrt (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_vld,
   input  wire logic [63:0]       in_rad,
   input  wire hsc_pkg::side_type in_side,
   output logic                   out_vld,
   output logic [31:0]            out_root,
   output hsc_pkg::side_type      out_side
);
   import hsc_pkg::*;

   logic [63:0] rem_ff  [1:SQRT_STAGES];
   logic [63:0] root_ff [1:SQRT_STAGES];
   side_type    side_ff [1:SQRT_STAGES];
   logic        vld_ff  [1:SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic [63:0] rem_cur, root_cur, bitv, trial, rem_in, root_in;
      side_type    side_cur;
      logic        vld_cur;

      if (k == 0) begin : g_first
         assign rem_cur  = in_rad;
         assign root_cur = '0;
         assign side_cur = in_side;
         assign vld_cur  = in_vld;
      end else begin : g_next
         assign rem_cur  = rem_ff[k];
         assign root_cur = root_ff[k];
         assign side_cur = side_ff[k];
         assign vld_cur  = vld_ff[k];
      end

      // Try one result bit
      always_comb begin
         bitv  = 64'd1 << (62 - 2 * k);
         trial = root_cur + bitv;
         if (rem_cur >= trial) begin
            rem_in  = rem_cur - trial;
            root_in = (root_cur >> 1) + bitv;
         end else begin
            rem_in  = rem_cur;
            root_in = root_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            side_ff[k+1] <= side_cur;
         end
      end
   end

   assign out_vld  = vld_ff[SQRT_STAGES];
   assign out_root = root_ff[SQRT_STAGES][31:0];
   assign out_side = side_ff[SQRT_STAGES];
endmodule
`default_nettype wire

@@ hdl/hsc_divide.sv @@
// Pipelined restoring divider for the light factor, with clamp and water override.
// Depends on hsc_pkg for light limits, stage count and the side payload type.
`default_nettype none
module hsc_divide (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_vld,
   input  wire logic [31:0]       in_root,
   input  wire hsc_pkg::side_type in_side,
   output logic                   out_vld,
   output logic [15:0]            out_light,
   output hsc_pkg::side_type      out_side
);
   import hsc_pkg::*;

   logic [35:0] den_in;
   logic [49:0] num_sh;

   // Setup stage: divisor, dividend and overflow check
   logic [35:0] den_ff  [0:DIV_STAGES];
   logic [51:0] rem_ff  [0:DIV_STAGES];
   logic [15:0] quo_ff  [0:DIV_STAGES];
   logic        sat_ff  [0:DIV_STAGES];
   side_type    side_ff [0:DIV_STAGES];
   logic        vld_ff  [0:DIV_STAGES];
   logic [15:0] light_in, light_ff;
   side_type    lside_ff;
   logic        lvld_ff;

   always_comb begin
      den_in = 36'(in_root) * 36'd10;
      num_sh = {in_side.num, 22'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= den_in;
         rem_ff[0]  <= 52'(num_sh);
         quo_ff[0]  <= '0;
         sat_ff[0]  <= ({2'b0, num_sh} >= {den_in, 16'b0});
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [51:0] shifted, rem_in;
      logic [15:0] quo_in;

      // Try one quotient bit
      always_comb begin
         shifted = 52'(den_ff[k]) << (DIV_STAGES - 1 - k);
         rem_in  = rem_ff[k];
         quo_in  = quo_ff[k];
         if (rem_ff[k] >= shifted) begin
            rem_in = rem_ff[k] - shifted;
            quo_in[DIV_STAGES-1-k] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k+1]  <= den_ff[k];
            rem_ff[k+1]  <= rem_in;
            quo_ff[k+1]  <= quo_in;
            sat_ff[k+1]  <= sat_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // Water takes unit light; otherwise clamp the quotient
   always_comb begin
      if (side_ff[DIV_STAGES].water) begin
         light_in = LIGHT_ONE;
      end else if (!side_ff[DIV_STAGES].num_pos) begin
         light_in = LIGHT_MIN;
      end else if (sat_ff[DIV_STAGES] || quo_ff[DIV_STAGES] > LIGHT_MAX) begin
         light_in = LIGHT_MAX;
      end else if (quo_ff[DIV_STAGES] < LIGHT_MIN) begin
         light_in = LIGHT_MIN;
      end else begin
         light_in = quo_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvld_ff <= 1'b0;
      end else if (en) begin
         lvld_ff <= vld_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         light_ff <= light_in;
         lside_ff <= side_ff[DIV_STAGES];
      end
   end

   assign out_vld   = lvld_ff;
   assign out_light = light_ff;
   assign out_side  = lside_ff;
endmodule
`default_nettype wire

@@ hdl/relief_shaded_height_colorizer.sv @@
// Relief-shaded height colorizer: one pixel per cycle sustained while responses are taken;
// the 32-stage square root and 16-stage divider set depth.
// The whole pipeline advances whenever the output register is empty or being taken.
// Synchronous active-high reset clears all valid bits and loads register defaults.
// Depends on hsc_pkg, hsc_if, hsc_front, hsc_isqrt and hsc_divide.
`default_nettype none
module relief_shaded_height_colorizer (
   input  wire logic        clock,
   input  wire logic        reset,
   hsc_req_if.sink          req,
   hsc_rsp_if.source        rsp,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import hsc_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type widx;
   logic          en;

   logic          f_vld, s_vld, d_vld;
   logic [63:0]   f_rad;
   side_type      f_side, s_side, d_side;
   logic [31:0]   s_root;
   logic [15:0]   d_light;

   logic          out_vld_ff;
   logic [7:0]    red_ff, green_ff, blue_ff;
   logic [7:0]    red_in, green_in, blue_in;

   // Configuration registers
   assign pready = 1'b1;
   assign widx   = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sea_level   <= 16'd26214;
         cfg_ff.grass_top   <= 16'd39322;
         cfg_ff.rock_top    <= 16'd55706;
         cfg_ff.relief_gain <= 8'd20;
      end else if (psel && penable && pwrite) begin
         case (widx)
            REG_SEA_LEVEL:   cfg_ff.sea_level   <= pwdata[15:0];
            REG_GRASS_TOP:   cfg_ff.grass_top   <= pwdata[15:0];
            REG_ROCK_TOP:    cfg_ff.rock_top    <= pwdata[15:0];
            REG_RELIEF_GAIN: cfg_ff.relief_gain <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (widx)
         REG_SEA_LEVEL:   prdata = {16'b0, cfg_ff.sea_level};
         REG_GRASS_TOP:   prdata = {16'b0, cfg_ff.grass_top};
         REG_ROCK_TOP:    prdata = {16'b0, cfg_ff.rock_top};
         REG_RELIEF_GAIN: prdata = {24'b0, cfg_ff.relief_gain};
         default:         prdata = '0;
      endcase
   end

   // Advance the pipeline unless a result sits unclaimed
   assign en        = !out_vld_ff || rsp.ready;
   assign req.ready = en;

   hsc_front u_front (
      .clock, .reset, .en,
      .in_vld        (req.valid),
      .center_height (req.center_height),
      .left_height   (req.left_height),
      .right_height  (req.right_height),
      .up_height     (req.up_height),
      .down_height   (req.down_height),
      .overlay_valid (req.overlay_valid),
      .overlay_red   (req.overlay_red),
      .overlay_green (req.overlay_green),
      .overlay_blue  (req.overlay_blue),
      .cfg           (cfg_ff),
      .out_vld       (f_vld),
      .out_rad       (f_rad),
      .out_side      (f_side)
   );

   hsc_isqrt u_isqrt (
      .clock, .reset, .en,
      .in_vld   (f_vld),
      .in_rad   (f_rad),
      .in_side  (f_side),
      .out_vld  (s_vld),
      .out_root (s_root),
      .out_side (s_side)
   );

   hsc_divide u_divide (
      .clock, .reset, .en,
      .in_vld    (s_vld),
      .in_root   (s_root),
      .in_side   (s_side),
      .out_vld   (d_vld),
      .out_light (d_light),
      .out_side  (d_side)
   );

   // Shade each channel and saturate
   function automatic logic [7:0] shade(input logic [7:0] c, input logic [15:0] l);
      logic [23:0] p;
      p = 24'(c) * 24'(l);
      return (p[23:15] > 9'd255) ? 8'd255 : p[22:15];
   endfunction

   always_comb begin
      red_in   = shade(d_side.red, d_light);
      green_in = shade(d_side.green, d_light);
      blue_in  = shade(d_side.blue, d_light);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= d_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp.valid       = out_vld_ff;
   assign rsp.pixel_red   = red_ff;
   assign rsp.pixel_green = green_ff;
   assign rsp.pixel_blue  = blue_ff;
endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking bench for relief_shaded_height_colorizer: streams pixels through the
// request channel, predicts the shaded colour of each, and checks every response beat.
// Depends on hsc_pkg, hsc_if and the colorizer RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import hsc_pkg::*;

   typedef struct packed {
      logic [15:0] center;
      logic [15:0] left_h;
      logic [15:0] right_h;
      logic [15:0] up_h;
      logic [15:0] down_h;
      logic        ovl;
      logic [7:0]  ovl_r;
      logic [7:0]  ovl_g;
      logic [7:0]  ovl_b;
   } pixel_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   localparam int LATENCY = 54;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   hsc_req_if req ();
   hsc_rsp_if rsp ();

   relief_shaded_height_colorizer uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Model copy of the configuration registers
   logic [15:0] sea_level_m, grass_top_m, rock_top_m;
   logic [7:0]  gain_m;

   pixel_type pending_pixels[$];
   color_type expected_colors[$];
   int send_idle_pct = 0, recv_idle_pct = 0;
   bit recv_hold = 1'b0;
   int errors = 0, mismatches = 0, beats_out = 0, watchdog = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [7:0] apply_light(input logic [7:0] c, input logic [63:0] l);
      logic [63:0] v;
      v = (64'(c) * l) >> 15;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // Compute the shaded colour of one pixel under the current register values
   function automatic color_type shade_pixel(input pixel_type p);
      longint h, s, dx, dy, num, d;
      logic [63:0] q, root, light, tg, tb;
      logic [7:0] cr, cg, cb;
      color_type o;
      h = p.center; s = sea_level_m;
      dx = (longint'(p.left_h) - longint'(p.right_h)) * longint'(gain_m);
      dy = (longint'(p.up_h) - longint'(p.down_h)) * longint'(gain_m);
      q = dx * dx + dy * dy + (64'd1 << 32);
      root = root64(q << 14);
      num = 5 * dx + 5 * dy + 7 * 65536;
      light = 0;
      if (num > 0) light = (64'(num) << 22) / (10 * root);
      if (light < 64'(LIGHT_MIN)) light = 64'(LIGHT_MIN);
      if (light > 64'(LIGHT_MAX)) light = 64'(LIGHT_MAX);
      if (h < s) begin
         d = s - h;
         tg = (200 * d + 65535) >> 16;
         tb = (500 * d + 65535) >> 16;
         light = 64'(LIGHT_ONE);
         if (100 * d < 65536) begin
            cr = 200; cg = 220; cb = 255;
         end else begin
            cr = 10;
            cg = (tg >= 80) ? 8'd0 : 8'(80 - tg);
            cb = (tb >= 180) ? 8'd0 : 8'(180 - tb);
         end
      end else if ((h - s) * 25 < 65536) begin
         cr = 210; cg = 200; cb = 130;
      end else if (h < grass_top_m) begin
         cr = 60; cg = 140; cb = 60;
      end else if (h < rock_top_m) begin
         cr = 100; cg = 90; cb = 80;
      end else begin
         cr = 240; cg = 240; cb = 255;
      end
      if (p.ovl) begin
         cr = p.ovl_r; cg = p.ovl_g; cb = p.ovl_b;
      end
      o.red = apply_light(cr, light);
      o.green = apply_light(cg, light);
      o.blue = apply_light(cb, light);
      return o;
   endfunction

   // Drive: offer the head of the pending queue, advance on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            expected_colors.push_back(shade_pixel(pending_pixels.pop_front()));
         end
         if ((!req.valid || req.ready) ) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req.valid <= 1'b1;
               {req.center_height, req.left_height, req.right_height, req.up_height,
                req.down_height, req.overlay_valid, req.overlay_red, req.overlay_green,
                req.overlay_blue} <= pending_pixels[0];
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response beat against the oldest expectation
   always @(posedge clock) begin
      color_type got, want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.pixel_red, rsp.pixel_green, rsp.pixel_blue};
            beats_out++;
            if (expected_colors.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected beat %h", got);
            end else begin
               want = expected_colors.pop_front();
               if (got !== want) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch: expected r%0d g%0d b%0d got r%0d g%0d b%0d",
                              want.red, want.green, want.blue,
                              got.red, got.green, got.blue);
               end
            end
         end
      end
   end

   // Watchdog: count cycles with no accepted beat on either channel
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset)
         watchdog <= 0;
      else
         watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_SEA_LEVEL:   sea_level_m = val[15:0];
         REG_GRASS_TOP:   grass_top_m = val[15:0];
         REG_ROCK_TOP:    rock_top_m = val[15:0];
         REG_RELIEF_GAIN: gain_m = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_bands(input logic [15:0] s, g, r, input logic [7:0] k);
      csr_write(REG_SEA_LEVEL, 32'(s));
      csr_write(REG_GRASS_TOP, 32'(g));
      csr_write(REG_ROCK_TOP, 32'(r));
      csr_write(REG_RELIEF_GAIN, 32'(k));
   endtask

   // Hold until every queued item has been taken and answered
   task automatic drain();
      wait (pending_pixels.size() == 0 && !req.valid && expected_colors.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [15:0] near(input logic [15:0] c, input int span);
      int v;
      v = int'(c) + $urandom_range(2 * span) - span;
      return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
   endfunction

   // Mostly smooth terrain around a random height, with some wild neighbours
   function automatic pixel_type random_pixel();
      pixel_type p;
      int span;
      p = {$urandom, $urandom, $urandom};
      span = ($urandom_range(3) == 0) ? 65535 : $urandom_range(4000);
      p.center = ($urandom_range(4) == 0) ? sea_level_m - 16'($urandom_range(1000))
                                         : 16'($urandom);
      p.left_h = near(p.center, span);
      p.right_h = near(p.center, span);
      p.up_h = near(p.center, span);
      p.down_h = near(p.center, span);
      p.ovl = ($urandom_range(4) == 0);
      return p;
   endfunction

   task automatic random_batch(input int n);
      repeat (n) pending_pixels.push_back(random_pixel());
   endtask

   function automatic pixel_type flat(input logic [15:0] h);
      return '{h, h, h, h, h, 1'b0, 8'd0, 8'd0, 8'd0};
   endfunction

   initial begin
      sea_level_m = 26214; grass_top_m = 39322; rock_top_m = 55706; gain_m = 20;
      req.valid = 1'b0;
      {req.center_height, req.left_height, req.right_height, req.up_height,
       req.down_height, req.overlay_valid, req.overlay_red, req.overlay_green,
       req.overlay_blue} = '0;
      rsp.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: every band, foam edge, steepest slopes, overlay on water and land
      pending_pixels.push_back(flat(16'd0));
      pending_pixels.push_back(flat(16'd26214 - 16'd655));
      pending_pixels.push_back(flat(16'd26214 - 16'd656));
      pending_pixels.push_back(flat(16'd26213));
      pending_pixels.push_back(flat(16'd26214));
      pending_pixels.push_back(flat(16'd28835));
      pending_pixels.push_back(flat(16'd39321));
      pending_pixels.push_back(flat(16'd55705));
      pending_pixels.push_back(flat(16'hFFFF));
      pending_pixels.push_back('{16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b0, 8'd0,
                                 8'd0, 8'd0});
      pending_pixels.push_back('{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0, 8'd0,
                                 8'd0, 8'd0});
      pending_pixels.push_back('{16'd50000, 16'd51000, 16'd50000, 16'd50000, 16'd49000,
                                 1'b1, 8'hFF, 8'hFF, 8'hFF});
      pending_pixels.push_back('{16'd100, 16'd100, 16'd100, 16'd100, 16'd100, 1'b1, 8'hFF,
                                 8'h00, 8'hAA});
      pending_pixels.push_back('{16'd60000, 16'd0, 16'd65535, 16'd65535, 16'd0, 1'b1,
                                 8'h55, 8'hFF, 8'h00});
      drain();

      // Phase 1: slow sender, very slow receiver, default bands
      send_idle_pct = 23; recv_idle_pct = 80;
      random_batch(200);
      drain();

      // Long receiver hold while the sender keeps offering, filling the pipeline
      set_bands(16'd0, 16'd0, 16'd0, 8'd0);
      recv_hold = 1'b1;
      send_idle_pct = 0;
      random_batch(150);
      repeat (400) @(posedge clock);
      recv_hold = 1'b0;
      drain();

      // Phase 2: swapped idling, extreme and disordered thresholds
      send_idle_pct = 80; recv_idle_pct = 23;
      set_bands(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
      random_batch(100);
      drain();
      set_bands(16'd30000, 16'd20000, 16'd60000, 8'd1);
      random_batch(100);
      drain();

      // Phase 3: no idling, assorted register values
      send_idle_pct = 0; recv_idle_pct = 0;
      set_bands(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)));
      random_batch(120);
      drain();
      set_bands(16'd26214, 16'd39322, 16'd55706, 8'd20);
      random_batch(130);
      drain();

      $display("covered %0d response beats over idle mixes, full stall and six band settings",
               beats_out);
      if (errors == 0 && expected_colors.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
